// ===== rtl/vpt_pkg.sv =====
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared types, constants and register indexes of the velocity pad trigger.
// ----------------------------------------------------------------------------
package vpt_pkg;

  localparam int PAD_TOTAL_DEF = 8;

  // event queue between sample classification and note building
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_TH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_BASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL   = 3'd6;

  localparam logic [9:0] FULL_SCALE   = 10'd1023;
  localparam logic [6:0] OFF_VELOCITY = 7'd64;
  localparam logic [6:0] NOTE_MAX     = 7'd127;

  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  // divider steps: the quotient never exceeds seven bits
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [2:0]  pad_index;
    logic [9:0]  level;
    logic [31:0] time_ms;
  } vpt_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] channel_out;
    logic [6:0] note_number;
    logic [6:0] velocity;
    logic [2:0] source_pad;
  } vpt_out_t;

  typedef struct packed {
    logic [9:0]  on_th;
    logic [9:0]  off_th;
    logic [15:0] window;
    logic [6:0]  vel_min;
    logic [6:0]  vel_max;
    logic [6:0]  note_base;
    logic [3:0]  channel;
  } vpt_cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] pad;
    logic [9:0] peak;
  } vpt_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vpt_qstat_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DETECT,
    PH_ACTIVE
  } vpt_phase_t;

  typedef enum logic {
    F_IDLE,
    F_EXEC
  } vpt_fstate_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_OUT
  } vpt_bstate_t;

endpackage

// ===== rtl/vpt_queue.sv =====
// ----------------------------------------------------------------------------
// vpt_queue
// Small event queue that decouples sample classification from note building.
// ----------------------------------------------------------------------------
module vpt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vpt_pkg::vpt_evt_t  push_evt,
  input  logic               pop,
  output vpt_pkg::vpt_evt_t  head_evt,
  output vpt_pkg::vpt_qstat_t stat
);
  import vpt_pkg::*;

  vpt_evt_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_evt;
    end
  end

  assign head_evt   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");

endmodule

// ===== rtl/vpt_front.sv =====
// ----------------------------------------------------------------------------
// vpt_front
// Accepts pad samples, runs each pad's phase machine and queues note events.
// ----------------------------------------------------------------------------
module vpt_front #(
  parameter int PAD_TOTAL = vpt_pkg::PAD_TOTAL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vpt_pkg::vpt_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  vpt_pkg::vpt_in_t    in_data,
  output logic                push,
  output vpt_pkg::vpt_evt_t   push_evt,
  input  vpt_pkg::vpt_qstat_t qstat
);
  import vpt_pkg::*;

  localparam int IDX_W = (PAD_TOTAL > 1) ? $clog2(PAD_TOTAL) : 1;
  localparam int EXT_W = 7;

  vpt_fstate_t      fstate_r, fstate_nxt;
  vpt_phase_t       phase_r [PAD_TOTAL];
  logic [9:0]       peak_mem [PAD_TOTAL];
  logic [31:0]      arm_mem [PAD_TOTAL];

  vpt_in_t          item_r;
  logic [9:0]       peak_rd_r;
  logic [31:0]      arm_rd_r;

  logic [EXT_W-1:0] in_pad_ext, item_pad_ext;
  logic [IDX_W-1:0] in_idx, item_idx;
  logic             accept, commit, pad_ok;
  logic             need_push, peak_we, arm_we, phase_we;
  logic [9:0]       peak_new, peak_wd;
  logic [31:0]      elapsed;
  vpt_phase_t       cur_phase, phase_wd;

  assign in_pad_ext   = {4'b0, in_data.pad_index};
  assign item_pad_ext = {4'b0, item_r.pad_index};
  assign in_idx       = in_pad_ext[IDX_W-1:0];
  assign item_idx     = item_pad_ext[IDX_W-1:0];
  assign pad_ok       = (item_pad_ext < EXT_W'(PAD_TOTAL));
  assign cur_phase    = phase_r[item_idx];
  assign elapsed      = item_r.time_ms - arm_rd_r;
  assign peak_new     = (item_r.level > peak_rd_r) ? item_r.level : peak_rd_r;

  // per-pad phase decision on the sample held in item_r
  always_comb begin
    need_push     = 1'b0;
    peak_we       = 1'b0;
    arm_we        = 1'b0;
    phase_we      = 1'b0;
    peak_wd       = peak_new;
    phase_wd      = cur_phase;
    push_evt.kind = EV_OFF;
    push_evt.pad  = item_r.pad_index;
    push_evt.peak = peak_new;
    if (pad_ok) begin
      case (cur_phase)
        PH_DETECT: begin
          peak_we = 1'b1;
          if (elapsed >= {16'd0, cfg.window}) begin
            need_push     = 1'b1;
            push_evt.kind = EV_ON;
            phase_we      = 1'b1;
            phase_wd      = PH_ACTIVE;
          end
        end
        PH_ACTIVE: begin
          if (item_r.level < cfg.off_th) begin
            need_push = 1'b1;
            phase_we  = 1'b1;
            phase_wd  = PH_IDLE;
          end
        end
        default: begin
          if (item_r.level >= cfg.on_th) begin
            peak_we  = 1'b1;
            peak_wd  = item_r.level;
            arm_we   = 1'b1;
            phase_we = 1'b1;
            phase_wd = PH_DETECT;
          end
        end
      endcase
    end
  end

  always_comb begin
    fstate_nxt = fstate_r;
    accept     = 1'b0;
    commit     = 1'b0;
    in_stall   = 1'b1;
    case (fstate_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept     = 1'b1;
          fstate_nxt = F_EXEC;
        end
      end
      F_EXEC: begin
        // hold the sample until the queue can take its event
        if (!(need_push && qstat.full)) begin
          commit     = 1'b1;
          fstate_nxt = F_IDLE;
        end
      end
      default: fstate_nxt = F_IDLE;
    endcase
  end

  assign push = commit && need_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
    end else begin
      fstate_r <= fstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_TOTAL; i++) begin
        phase_r[i] <= PH_IDLE;
      end
    end else if (commit && phase_we) begin
      phase_r[item_idx] <= phase_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_data;
      peak_rd_r <= peak_mem[in_idx];
      arm_rd_r  <= arm_mem[in_idx];
    end
    if (commit && peak_we) begin
      peak_mem[item_idx] <= peak_wd;
    end
    if (commit && arm_we) begin
      arm_mem[item_idx] <= item_r.time_ms;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("event pushed into full queue");

endmodule

// ===== rtl/vpt_back.sv =====
// ----------------------------------------------------------------------------
// vpt_back
// Turns queued events into note words: velocity map with a serial divider.
// ----------------------------------------------------------------------------
module vpt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vpt_pkg::vpt_cfg_t   cfg,
  input  vpt_pkg::vpt_evt_t   head_evt,
  input  vpt_pkg::vpt_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output vpt_pkg::vpt_out_t   out_data
);
  import vpt_pkg::*;

  vpt_bstate_t       bstate_r, bstate_nxt;
  vpt_evt_t          evt_r;
  logic [16:0]       rem_r;
  logic [16:0]       dsh_r;
  logic [6:0]        quo_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              full_r;
  logic              out_valid_r;
  vpt_out_t          out_r;

  logic              mul_go, div_go, load;
  logic [9:0]        clamped, delta, span_in;
  logic [7:0]        span_out;
  logic [6:0]        span_mag;
  logic [16:0]       prod;
  logic [7:0]        vel_sum;
  logic [6:0]        vel_on, vel;
  logic [7:0]        note_sum;
  logic [6:0]        note;

  assign clamped  = (evt_r.peak < cfg.on_th) ? cfg.on_th : evt_r.peak;
  assign delta    = clamped - cfg.on_th;
  assign span_in  = FULL_SCALE - cfg.on_th;
  assign span_out = {1'b0, cfg.vel_max} - {1'b0, cfg.vel_min};
  assign span_mag = span_out[7] ? 7'(-span_out) : span_out[6:0];
  assign prod     = {7'b0, delta} * {10'b0, span_mag};

  // truncation toward zero: divide magnitudes, apply the sign afterwards
  assign vel_sum = neg_r ? ({1'b0, cfg.vel_min} - {1'b0, quo_r})
                         : ({1'b0, cfg.vel_min} + {1'b0, quo_r});
  always_comb begin
    vel_on = full_r ? cfg.vel_max : vel_sum[6:0];
    if (vel_on == '0) begin
      vel_on = 7'd1;
    end
    vel = (evt_r.kind == EV_ON) ? vel_on : OFF_VELOCITY;
  end

  assign note_sum = {1'b0, cfg.note_base} + {5'b0, evt_r.pad};
  assign note     = note_sum[7] ? NOTE_MAX : note_sum[6:0];

  always_comb begin
    bstate_nxt = bstate_r;
    pop        = 1'b0;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    load       = 1'b0;
    case (bstate_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          bstate_nxt = (head_evt.kind == EV_ON) ? B_MUL : B_OUT;
        end
      end
      B_MUL: begin
        mul_go     = 1'b1;
        bstate_nxt = B_DIV;
      end
      B_DIV: begin
        div_go = 1'b1;
        if (step_r == '0) begin
          bstate_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load       = 1'b1;
          bstate_nxt = B_IDLE;
        end
      end
      default: bstate_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r <= bstate_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      evt_r <= head_evt;
    end
    if (mul_go) begin
      rem_r  <= prod;
      dsh_r  <= {1'b0, span_in, 6'b0};
      quo_r  <= '0;
      step_r <= STEP_W'(DIV_STEPS - 1);
      neg_r  <= span_out[7];
      full_r <= (cfg.on_th == FULL_SCALE);
    end
    if (div_go) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[5:0], 1'b1};
      end else begin
        quo_r <= {quo_r[5:0], 1'b0};
      end
      dsh_r  <= {1'b0, dsh_r[16:1]};
      step_r <= step_r - 1'b1;
    end
    if (load) begin
      out_r.event_kind  <= evt_r.kind;
      out_r.channel_out <= cfg.channel;
      out_r.note_number <= note;
      out_r.velocity    <= vel;
      out_r.source_pad  <= evt_r.pad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_vel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    load && evt_r.kind == EV_ON |=> out_r.velocity != '0)
    else $error("note-on with zero velocity");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    bstate_r == B_MUL |-> ##(DIV_STEPS + 1) bstate_r == B_OUT)
    else $error("divider step count off");

endmodule

// ===== rtl/velocity_pad_trigger_top.sv =====
// ----------------------------------------------------------------------------
// velocity_pad_trigger_top
// Velocity sensitive drum pad trigger: pad samples in, note words out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pad sample per word (pad index, 10-bit level, ms timestamp).
//           A word is taken when in_valid is high and in_stall is low.
//   out_* : note-on / note-off words, taken when out_valid and !out_stall.
//   cfg_* : register writes by index, cfg_ready is always high; write only
//           while no sample is in flight.
// Timing:
//   a sample occupies the classifier for a pad state read, then an update
//   that waits while the queue is full and an event is due; no new sample is
//   taken before that update. The note builder handles a note-off as pop, load
//   and a note-on as pop, multiply, 7-step restoring divide, load, and pops no new event before that load.
// Stall:
//   a stalled result holds in the output register; the four-entry event
//   queue keeps samples flowing until it fills, then in_stall rises.
// Reset:
//   synchronous, rst_n low: registers return to their defaults, all pads go
//   idle, queue and output empty. Pad peak and arm time need no clearing.
// ----------------------------------------------------------------------------
module velocity_pad_trigger_top #(
  parameter int PAD_TOTAL = vpt_pkg::PAD_TOTAL_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vpt_pkg::vpt_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vpt_pkg::vpt_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vpt_pkg::*;

  vpt_cfg_t   cfg_r;
  vpt_evt_t   push_evt, head_evt;
  vpt_qstat_t qstat;
  logic       push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_th     <= 10'd100;
      cfg_r.off_th    <= 10'd60;
      cfg_r.window    <= 16'd5;
      cfg_r.vel_min   <= 7'd1;
      cfg_r.vel_max   <= 7'd127;
      cfg_r.note_base <= 7'd36;
      cfg_r.channel   <= 4'd9;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ON_TH:     cfg_r.on_th     <= cfg_data[9:0];
        CFG_OFF_TH:    cfg_r.off_th    <= cfg_data[9:0];
        CFG_WINDOW:    cfg_r.window    <= cfg_data;
        CFG_VEL_MIN:   cfg_r.vel_min   <= cfg_data[6:0];
        CFG_VEL_MAX:   cfg_r.vel_max   <= cfg_data[6:0];
        CFG_NOTE_BASE: cfg_r.note_base <= cfg_data[6:0];
        CFG_CHANNEL:   cfg_r.channel   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  vpt_front #(
    .PAD_TOTAL (PAD_TOTAL)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_evt (push_evt),
    .qstat    (qstat)
  );

  vpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .stat     (qstat)
  );

  vpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_evt  (head_evt),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the velocity pad trigger: a directed list of pad
// strikes and register settings, then random strike sequences over eight pads
// under changing idle and stall mixes, each note word compared with a
// per-pad phase tracker kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  import vpt_pkg::*;

  localparam int PADS          = PAD_TOTAL_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 205;
  localparam int SET_LOW       = 0;
  localparam int SET_HIGH      = 1;
  localparam int SET_MIXED     = 2;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    vpt_in_t               smp;
    bit                    typed;
    vpt_out_t              note;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  vpt_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  vpt_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // bench copy of the registers and of every pad
  vpt_cfg_t    cfg_m;
  vpt_phase_t  pad_ph   [PADS];
  logic [9:0]  pad_peak [PADS];
  logic [31:0] pad_arm  [PADS];
  logic [31:0] pad_clock [PADS];

  vpt_out_t  note_q [$];
  plan_row_t plan [$];

  int  errors     = 0;
  int  samples    = 0;
  int  ons        = 0;
  int  offs       = 0;
  int  settings   = 0;
  int  idle_pct   = 0;
  int  stall_pct  = 0;
  int  hold_asked = 0;
  int  hold_seen  = 0;
  int  hold_left  = 0;
  bit  in_hot     = 0;

  int idle_mix  [4] = '{0, 69, 0, 20};
  int stall_mix [4] = '{0, 0, 69, 20};

  velocity_pad_trigger_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [6:0] map_velocity(logic [9:0] peak);
    int clamped, span_in, span_out, v;
    clamped = int'(peak);
    if (clamped < int'(cfg_m.on_th)) clamped = int'(cfg_m.on_th);
    if (cfg_m.on_th == FULL_SCALE) begin
      v = int'(cfg_m.vel_max);
    end else begin
      span_in  = int'(FULL_SCALE) - int'(cfg_m.on_th);
      span_out = int'(cfg_m.vel_max) - int'(cfg_m.vel_min);
      // signed divide, truncates toward zero
      v = ((clamped - int'(cfg_m.on_th)) * span_out) / span_in + int'(cfg_m.vel_min);
    end
    if (v <= 0) v = 1;
    return v[6:0];
  endfunction

  function automatic vpt_out_t build_note(logic kind, logic [2:0] p, logic [6:0] vel);
    vpt_out_t r;
    int n;
    n = int'(cfg_m.note_base) + int'(p);
    if (n > int'(NOTE_MAX)) n = int'(NOTE_MAX);
    r.event_kind  = kind;
    r.channel_out = cfg_m.channel;
    r.note_number = n[6:0];
    r.velocity    = vel;
    r.source_pad  = p;
    return r;
  endfunction

  function automatic bit predict_note(input vpt_in_t s, output vpt_out_t note);
    logic [2:0]  p;
    logic [31:0] elapsed;
    p = s.pad_index;
    note = '0;
    predict_note = 0;
    case (pad_ph[p])
      PH_DETECT: begin
        if (s.level > pad_peak[p]) pad_peak[p] = s.level;
        elapsed = s.time_ms - pad_arm[p];
        if (elapsed >= cfg_m.window) begin
          note = build_note(EV_ON, p, map_velocity(pad_peak[p]));
          pad_ph[p] = PH_ACTIVE;
          predict_note = 1;
        end
      end
      PH_ACTIVE: begin
        if (s.level < cfg_m.off_th) begin
          note = build_note(EV_OFF, p, OFF_VELOCITY);
          pad_ph[p] = PH_IDLE;
          predict_note = 1;
        end
      end
      default: begin
        if (s.level >= cfg_m.on_th) begin
          pad_ph[p]   = PH_DETECT;
          pad_peak[p] = s.level;
          pad_arm[p]  = s.time_ms;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic push_sample(input vpt_in_t s, input bit typed, input vpt_out_t typed_note);
    vpt_out_t note;
    int gap;
    in_valid <= 1'b1;
    in_data  <= s;
    in_hot = 1;
    do @(posedge clk); while (in_stall);
    if (predict_note(s, note)) begin
      if (typed) note = typed_note;
      note_q.push_back(note);
    end
    samples++;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_hot = 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ON_TH:     cfg_m.on_th     = val[9:0];
      CFG_OFF_TH:    cfg_m.off_th    = val[9:0];
      CFG_WINDOW:    cfg_m.window    = val;
      CFG_VEL_MIN:   cfg_m.vel_min   = val[6:0];
      CFG_VEL_MAX:   cfg_m.vel_max   = val[6:0];
      CFG_NOTE_BASE: cfg_m.note_base = val[6:0];
      CFG_CHANNEL:   cfg_m.channel   = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait for every expected note, then let in-flight samples retire
  task automatic settle();
    int waited;
    if (in_hot) begin
      in_valid <= 1'b0;
      in_hot = 0;
    end
    waited = 0;
    while (note_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (note_q.size() != 0) begin
      $error("%0d expected note words never arrived", note_q.size());
      errors++;
      note_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick(int hi, int typ_hi, int mode);
    int r;
    if (mode == SET_LOW) return 0;
    if (mode == SET_HIGH) return hi;
    r = $urandom_range(3);
    if (r == 0) return 0;
    if (r == 1) return hi;
    return $urandom_range(typ_hi);
  endfunction

  task automatic pick_setting(input int mode);
    write_reg(CFG_ON_TH,     16'(pick(1023, 1023, mode)));
    write_reg(CFG_OFF_TH,    16'(pick(1023, 1023, mode)));
    write_reg(CFG_WINDOW,    16'(pick(65535, 12, mode)));
    write_reg(CFG_VEL_MIN,   16'(pick(127, 127, mode)));
    write_reg(CFG_VEL_MAX,   16'(pick(127, 127, mode)));
    write_reg(CFG_NOTE_BASE, 16'(pick(127, 127, mode)));
    write_reg(CFG_CHANNEL,   16'(pick(15, 15, mode)));
    settings++;
  endtask

  // mostly well-formed strikes: arm, track the peak, pass the window, release
  function automatic vpt_in_t next_sample();
    vpt_in_t s;
    logic [2:0] p;
    int adv;
    p = 3'($urandom_range(PADS - 1));
    s.pad_index = p;
    if ($urandom_range(99) < 8) begin
      s.level   = 10'($urandom_range(1023));
      s.time_ms = $urandom();
      return s;
    end
    case (pad_ph[p])
      PH_IDLE: begin
        s.level = 10'(($urandom_range(99) < 80) ? $urandom_range(1023, cfg_m.on_th)
                                                : $urandom_range(1023));
        adv = $urandom_range(3);
      end
      PH_DETECT: begin
        s.level = 10'($urandom_range(1023));
        adv = $urandom_range(1) ? int'(cfg_m.window) + $urandom_range(3)
                                : $urandom_range(cfg_m.window);
      end
      default: begin
        s.level = 10'(($urandom_range(1) && cfg_m.off_th != 0)
                      ? $urandom_range(cfg_m.off_th - 1)
                      : $urandom_range(1023));
        adv = $urandom_range(3);
      end
    endcase
    pad_clock[p] = pad_clock[p] + adv;
    s.time_ms = pad_clock[p];
    return s;
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = val;
    r.smp = '0;
    r.typed = 0;
    r.note = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_sample(logic [2:0] p, logic [9:0] lvl, logic [31:0] t);
    plan_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = '0;
    r.val = '0;
    r.smp = '{pad_index: p, level: lvl, time_ms: t};
    r.typed = 0;
    r.note = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_note(logic [2:0] p, logic [9:0] lvl, logic [31:0] t,
                                    logic kind, logic [3:0] ch, logic [6:0] nn, logic [6:0] vel);
    plan_sample(p, lvl, t);
    plan[$].typed = 1;
    plan[$].note = '{event_kind: kind, channel_out: ch, note_number: nn, velocity: vel,
                     source_pad: p};
  endfunction

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    vpt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (note_q.size() == 0) begin
        $error("note word with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = note_q.pop_front();
        check_field("event_kind",  7'(want.event_kind),  7'(out_data.event_kind));
        check_field("channel_out", 7'(want.channel_out), 7'(out_data.channel_out));
        check_field("note_number", want.note_number, out_data.note_number);
        check_field("velocity",    want.velocity,    out_data.velocity);
        check_field("source_pad",  7'(want.source_pad),  7'(out_data.source_pad));
        if (want.event_kind == EV_ON) ons++;
        else offs++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_m = '{on_th: 10'd100, off_th: 10'd60, window: 16'd5, vel_min: 7'd1,
              vel_max: 7'd127, note_base: 7'd36, channel: 4'd9};
    for (int i = 0; i < PADS; i++) begin
      pad_ph[i]    = PH_IDLE;
      pad_peak[i]  = '0;
      pad_arm[i]   = '0;
      pad_clock[i] = (i < 3) ? 32'hFFFF_FFF0 + 32'(i) : $urandom();
    end

    // reset values: full-scale peak, threshold peak across the time wrap
    plan_sample(3'd0, 10'd1023, 32'd0);
    plan_sample(3'd0, 10'd0,    32'd4);
    plan_note  (3'd0, 10'd500,  32'd5, EV_ON,  4'd9, 7'd36, 7'd127);
    plan_note  (3'd0, 10'd0,    32'd6, EV_OFF, 4'd9, 7'd36, OFF_VELOCITY);
    plan_sample(3'd7, 10'd100,  32'hFFFF_FFFE);
    plan_note  (3'd7, 10'd99,   32'd3, EV_ON,  4'd9, 7'd43, 7'd1);
    plan_sample(3'd7, 10'd60,   32'd4);
    plan_note  (3'd7, 10'd59,   32'd5, EV_OFF, 4'd9, 7'd43, OFF_VELOCITY);
    plan_sample(3'd3, 10'd99,   32'd10);
    plan_sample(3'd3, 10'd600,  32'd10);
    plan_sample(3'd3, 10'd700,  32'd12);
    plan_sample(3'd3, 10'd0,    32'd15);
    plan_sample(3'd3, 10'd1023, 32'd16);
    plan_note  (3'd3, 10'd0,    32'd17, EV_OFF, 4'd9, 7'd39, OFF_VELOCITY);
    // threshold at full scale, zero window, note saturation
    plan_write(CFG_ON_TH,     16'd1023);
    plan_write(CFG_OFF_TH,    16'd1023);
    plan_write(CFG_WINDOW,    16'd0);
    plan_write(CFG_VEL_MAX,   16'd0);
    plan_write(CFG_NOTE_BASE, 16'd127);
    plan_write(CFG_CHANNEL,   16'd15);
    plan_sample(3'd5, 10'd1023, 32'd100);
    plan_note  (3'd5, 10'd0,    32'd100, EV_ON,  4'd15, 7'd127, 7'd1);
    plan_note  (3'd5, 10'd1022, 32'd100, EV_OFF, 4'd15, 7'd127, OFF_VELOCITY);
    // zero thresholds, widest window, descending velocity range
    plan_write(CFG_ON_TH,     16'd0);
    plan_write(CFG_OFF_TH,    16'd0);
    plan_write(CFG_WINDOW,    16'd65535);
    plan_write(CFG_VEL_MIN,   16'd127);
    plan_write(CFG_NOTE_BASE, 16'd0);
    plan_write(CFG_CHANNEL,   16'd0);
    plan_sample(3'd1, 10'd0,   32'd0);
    plan_sample(3'd1, 10'd512, 32'd65534);
    plan_sample(3'd1, 10'd0,   32'd65535);
    plan_sample(3'd1, 10'd0,   32'd70000);
    plan_write(CFG_OFF_TH,  16'd1);
    plan_note  (3'd1, 10'd0, 32'd1, EV_OFF, 4'd0, 7'd1, OFF_VELOCITY);
    // flat zero range maps to zero, which is lifted to one
    plan_write(CFG_VEL_MIN, 16'd0);
    plan_sample(3'd2, 10'd5, 32'd0);
    plan_note  (3'd2, 10'd0, 32'd65535, EV_ON, 4'd0, 7'd2, 7'd1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_sample(plan[i].smp, plan[i].typed, plan[i].note);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      idle_pct  = idle_mix[ph % 4];
      stall_pct = stall_mix[ph % 4];
      pick_setting(ph == 2 ? SET_LOW : (ph == 5 ? SET_HIGH : SET_MIXED));
      // long output hold while samples keep coming, so the input backs up
      if (ph == 4) hold_asked <= hold_asked + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_sample(next_sample(), 0, '0);
        if (ph == 3 && n == PHASE_ITEMS / 2) settle();
      end
    end

    settle();
    $display("%0d pad samples sent, %0d note-on and %0d note-off words checked",
             samples, ons, offs);
    $display("%0d random register settings incl. all-low and all-high, four idle/stall mixes",
             settings);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
